// ----- sv/sbr_pkg.sv -----
package sbr_pkg;

	localparam int BAR_COUNT_DEF = 64;
	localparam int LEVELS_DEF    = 32;

	localparam int BIN_W       = 6;
	localparam int MAG_W       = 16;
	localparam int GAIN_W      = 4;
	localparam int OFFSET_W    = 4;
	localparam int CFG_DATA_W  = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int COL_W       = 7;
	localparam int SROW_W      = 5;
	localparam int CH_W        = 8;
	localparam int RGB_W       = 24;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	// The radicand covers magnitude * (gain * LEVELS)^2 at the widest LEVELS.
	localparam int N_W    = 34;
	localparam int S_W    = N_W / 2;
	localparam int FRAC_W = 8;
	localparam int LVL_W  = 7;
	localparam int SUM_W  = LVL_W + 1;

	localparam logic [GAIN_W-1:0]   GAIN_RST   = 4'd3;
	localparam logic [OFFSET_W-1:0] OFFSET_RST = 4'd4;

	localparam logic [RGB_W-1:0] COLOR_GREEN  = 24'h00C800;
	localparam logic [RGB_W-1:0] COLOR_YELLOW = 24'h969600;
	localparam logic [RGB_W-1:0] COLOR_ORANGE = 24'hFA6400;
	localparam logic [RGB_W-1:0] COLOR_RED    = 24'hC80000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN   = 1'b0,
		CFG_OFFSET = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SQRT,
		ST_LEVEL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [S_W-1:0] root;
		logic           rem_zero;
	} sqrt_res_t;

	function automatic logic [RGB_W-1:0] palette_rgb(input logic [SROW_W-1:0] r);
		priority if (r < 5'd11) begin
			return COLOR_GREEN;
		end else if (r < 5'd21) begin
			return COLOR_YELLOW;
		end else if (r < 5'd27) begin
			return COLOR_ORANGE;
		end else begin
			return COLOR_RED;
		end
	endfunction

endpackage

// ----- sv/sbr_isqrt.sv -----
module sbr_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [sbr_pkg::N_W-1:0]  operand,
	output logic                     done,
	output sbr_pkg::sqrt_res_t       res
);
	import sbr_pkg::*;

	localparam int RW    = S_W + 3;
	localparam int CNT_W = $clog2(S_W + 1);

	logic [N_W-1:0]   n_q;
	logic [RW-1:0]    rem_q;
	logic [S_W-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW-1:0] shifted;
	logic [RW-1:0] trial;
	logic          ge;

	assign shifted = {rem_q[RW-3:0], n_q[N_W-1 -: 2]};
	assign trial   = RW'({root_q, 2'b01});
	assign ge      = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(S_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= n_q << 2;
			rem_q  <= ge ? (shifted - trial) : shifted;
			root_q <= {root_q[S_W-2:0], ge};
		end
	end

	assign done         = done_q;
	assign res.root     = root_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

// ----- sv/spectrum_bar_renderer.sv -----
// A bar is accepted while idle, then passes the MUL1 and MUL2 multiply states, the square-root
// state (17 iterations and a done step), the level state and 2*LEVELS pixel loads, which an
// output stall (m_tready low) holds back. No new bar is taken until its last pixel is loaded.
// A bar whose index is not below BAR_COUNT is accepted and dropped at once. arst_n clears
// the sequencer and output valid, sets gain to 3, offset to 4 and the previous level to zero.
module spectrum_bar_renderer #(
	parameter int BAR_COUNT = sbr_pkg::BAR_COUNT_DEF,
	parameter int LEVELS    = sbr_pkg::LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// bin_index[5:0], magnitude[21:6], zero[23:22]
	input  logic [sbr_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// column[6:0], screen_row[11:7], red[19:12], green[27:20], blue[35:28], zero[39:36]
	output logic [sbr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [sbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sbr_pkg::*;

	localparam int ROW_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LSQ   = LEVELS * LEVELS;
	localparam int P1_W  = MAG_W + 2 * GAIN_W;
	localparam int WR_W  = S_W - FRAC_W + 2;

	state_t state_q, state_d;

	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [BIN_W-1:0]    bin_q;
	logic [MAG_W-1:0]    mag_q;
	logic [2*GAIN_W-1:0] gsq_q;
	logic [P1_W-1:0]     p1_q;
	logic signed [LVL_W-1:0] lvl_q, avg_q, prev_q;
	logic [ROW_W-1:0]    row_q;
	logic                side_q;

	logic                   m_tvalid_q;
	logic [COL_W-1:0]       col_q;
	logic [SROW_W-1:0]      srow_q;
	logic [RGB_W-1:0]       rgb_q;
	logic                   last_q;

	logic       in_fire, bin_ok, sq_start, sq_done, load, last_pix;
	logic [N_W-1:0] radicand;
	sqrt_res_t  sq_res;

	logic [BIN_W:0] bin_ext;
	assign in_fire = s_tvalid && s_tready;
	assign bin_ext = {1'b0, s_tdata[BIN_W-1:0]};
	assign bin_ok  = bin_ext < (BIN_W + 1)'(BAR_COUNT);

	assign radicand = N_W'(p1_q) * N_W'(LSQ);

	sbr_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (radicand),
		.done    (sq_done),
		.res     (sq_res)
	);

	// Level: floor of the scaled root, truncated toward zero after the offset.
	logic signed [WR_W-1:0] whole_s, off_s, lvl_raw;
	logic                   exact, bump;
	logic signed [LVL_W-1:0] lvl_cap, avg_new;
	logic signed [SUM_W-1:0] sum, sum_adj;

	always_comb begin
		whole_s = $signed({2'b00, sq_res.root[S_W-1:FRAC_W]});
		off_s   = $signed({{(WR_W-OFFSET_W){1'b0}}, offset_q});
		exact   = sq_res.rem_zero && (sq_res.root[FRAC_W-1:0] == '0);
		bump    = (whole_s < off_s) && !exact;
		lvl_raw = whole_s - off_s + $signed({{(WR_W-1){1'b0}}, bump});
		if (lvl_raw > $signed(WR_W'(LEVELS))) begin
			lvl_cap = LVL_W'(LEVELS);
		end else begin
			lvl_cap = lvl_raw[LVL_W-1:0];
		end
		sum     = {prev_q[LVL_W-1], prev_q} + {lvl_cap[LVL_W-1], lvl_cap};
		sum_adj = sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]});
		avg_new = sum_adj[SUM_W-1:1];
	end

	// Pixel of the current emit position.
	logic signed [LVL_W-1:0] height;
	logic                    lit;
	logic [RGB_W-1:0]        pix_rgb;

	always_comb begin
		height   = side_q ? lvl_q : avg_q;
		lit      = !height[LVL_W-1] && ({{(LVL_W-ROW_W){1'b0}}, row_q} < height[LVL_W-1:0]);
		pix_rgb  = lit ? palette_rgb(SROW_W'(row_q)) : '0;
		last_pix = side_q && (row_q == ROW_W'(LEVELS - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire && bin_ok) state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_SQRT;
			ST_SQRT:  if (sq_done) state_d = ST_LEVEL;
			ST_LEVEL: state_d = ST_EMIT;
			ST_EMIT:  if (load && last_pix) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		sq_start = (state_q == ST_MUL2);
		load     = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gain_q     <= GAIN_RST;
			offset_q   <= OFFSET_RST;
			prev_q     <= '0;
			m_tvalid_q <= 1'b0;
			row_q      <= '0;
			side_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
					CFG_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
					default:    ;
				endcase
			end
			if (state_q == ST_LEVEL) begin
				prev_q <= lvl_cap;
				row_q  <= '0;
				side_q <= 1'b0;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
				if (row_q == ROW_W'(LEVELS - 1)) begin
					row_q  <= '0;
					side_q <= 1'b1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bin_q <= s_tdata[BIN_W-1:0];
			mag_q <= s_tdata[BIN_W +: MAG_W];
			gsq_q <= gain_q * gain_q;
		end
		if (state_q == ST_MUL1) begin
			p1_q <= P1_W'(mag_q) * P1_W'(gsq_q);
		end
		if (state_q == ST_LEVEL) begin
			lvl_q <= lvl_cap;
			avg_q <= avg_new;
		end
		if (load) begin
			col_q  <= {bin_q, side_q};
			srow_q <= SROW_W'(LEVELS - 1) - SROW_W'(row_q);
			rgb_q  <= pix_rgb;
			last_q <= last_pix;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_TDATA_W - COL_W - SROW_W - 3*CH_W){1'b0}},
		rgb_q[CH_W-1:0], rgb_q[2*CH_W-1:CH_W], rgb_q[3*CH_W-1:2*CH_W], srow_q, col_q};

endmodule

// ----- sv/sbr_checker.sv -----
module sbr_checker #(
	parameter int BAR_COUNT = sbr_pkg::BAR_COUNT_DEF,
	parameter int LEVELS    = sbr_pkg::LEVELS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [sbr_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sbr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                             m_tlast,
	input logic                             cfg_we,
	input logic [sbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [sbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sbr_pkg::*;

	logic [BIN_W:0] bin_ext;
	assign bin_ext = {1'b0, s_tdata[BIN_W-1:0]};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transfer changed");

	a_busy_after_bar: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (bin_ext < (BIN_W + 1)'(BAR_COUNT)) |=> !s_tready)
		else $error("input ready while a bar is being rendered");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[COL_W +: SROW_W]} < (SROW_W + 1)'(LEVELS))
		else $error("screen row out of range");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[COL_W +: SROW_W] == '0) && m_tdata[0])
		else $error("last pixel is not the top of the right column");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_tready && !m_tvalid && !$isunknown({cfg_index, cfg_data}))
		else $error("configuration write while a bar is in flight");

endmodule

bind spectrum_bar_renderer sbr_checker #(.BAR_COUNT(BAR_COUNT), .LEVELS(LEVELS)) u_sbr_checker (.*);
